// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, held off during reset
`define ASSERT_IMPL(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clock, rst_n, ante, cons)
`define ASSERT_NEXT(label, clock, rst_n, ante, cons)

`endif

`endif

// ===== sv/qpe_pkg.sv =====
// ----------------------------------------------------------------------------
// qpe_pkg
// types and constants shared by the qoi pixel encoder modules
// ----------------------------------------------------------------------------
package qpe_pkg;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} qpe_pixel_t;

	// chunk list for one pixel: run byte first, then the main chunk
	typedef struct packed {
		logic [5:0][7:0] bytes;
		logic [2:0]      nb;
		logic            eoi;
	} qpe_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qpe_qstat_t;

	localparam qpe_pixel_t PIXEL_RESET = 32'h0000_00FF;

	localparam logic [5:0] RUN_MAX = 6'd62;
	localparam int         INDEX_DEPTH = 64;
	localparam int         PIXEL_W = 32;

	localparam logic [7:0] TAG_INDEX = 8'h00;
	localparam logic [7:0] TAG_DIFF  = 8'h40;
	localparam logic [7:0] TAG_LUMA  = 8'h80;
	localparam logic [7:0] TAG_RUN   = 8'hC0;
	localparam logic [7:0] TAG_RGB   = 8'hFE;
	localparam logic [7:0] TAG_RGBA  = 8'hFF;

	localparam logic [3:0] MARKER_LEN  = 4'd8;
	localparam logic [7:0] MARKER_PAD  = 8'h00;
	localparam logic [7:0] MARKER_LAST = 8'h01;

endpackage

// ===== sv/qpe_ram.sv =====
// ----------------------------------------------------------------------------
// qpe_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module qpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/qpe_front.sv =====
// ----------------------------------------------------------------------------
// qpe_front
// takes pixels, keeps run, previous pixel and index, builds chunk lists
// ----------------------------------------------------------------------------
module qpe_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         pixel_red,
	input  logic [7:0]         pixel_green,
	input  logic [7:0]         pixel_blue,
	input  logic [7:0]         pixel_alpha,
	input  logic               end_of_image,
	output logic               push,
	output qpe_pkg::qpe_entry_t push_entry,
	input  qpe_pkg::qpe_qstat_t q_stat
);

	localparam int HW = $clog2(qpe_pkg::INDEX_DEPTH);

	logic                accept;
	logic [HW-1:0]       in_hash;
	qpe_pkg::qpe_pixel_t in_pix;

	logic                valid_s1;
	qpe_pkg::qpe_pixel_t pix_s1;
	logic [HW-1:0]       hash_s1;
	logic                eoi_s1;
	logic                fwd_s1;
	qpe_pkg::qpe_pixel_t fwd_pix_s1;
	logic                idx_ok_s1;

	qpe_pkg::qpe_pixel_t prev_q;
	logic [5:0]          run_q;
	logic [qpe_pkg::INDEX_DEPTH-1:0] vbits_q;

	logic [qpe_pkg::PIXEL_W-1:0] ram_rdata;
	qpe_pkg::qpe_pixel_t entry_pix;

	logic              same;
	logic [5:0]        run_inc;
	logic [5:0]        run_next;
	logic              run_en;
	logic [7:0]        run_byte;
	logic              tbl_wr;
	logic [4:0][7:0]   main_b;
	logic [2:0]        main_n;
	logic              push_req;
	logic              go;
	logic              fire;

	logic signed [7:0] dr, dg, db;
	logic signed [8:0] rg, bg;
	logic        [7:0] drp, dgp, dbp, dgl;
	logic        [8:0] rgp, bgp;
	logic              diff_ok, luma_ok;

	assign in_pix  = {pixel_red, pixel_green, pixel_blue, pixel_alpha};
	// (3r + 5g + 7b + 11a) mod 64, kept in six bits throughout
	assign in_hash = pixel_red[HW-1:0] * HW'(3) + pixel_green[HW-1:0] * HW'(5)
		+ pixel_blue[HW-1:0] * HW'(7) + pixel_alpha[HW-1:0] * HW'(11);

	// index slot: forwarded write beats ram, unwritten slot reads as zero
	assign entry_pix = fwd_s1 ? fwd_pix_s1
		: (idx_ok_s1 ? qpe_pkg::qpe_pixel_t'(ram_rdata) : '0);

	assign same    = (pix_s1 == prev_q);
	assign run_inc = run_q + 6'd1;

	assign dr  = $signed(pix_s1.r - prev_q.r);
	assign dg  = $signed(pix_s1.g - prev_q.g);
	assign db  = $signed(pix_s1.b - prev_q.b);
	assign rg  = {dr[7], dr} - {dg[7], dg};
	assign bg  = {db[7], db} - {dg[7], dg};
	assign drp = dr + 8'sd2;
	assign dgp = dg + 8'sd2;
	assign dbp = db + 8'sd2;
	assign dgl = dg + 8'sd32;
	assign rgp = rg + 9'sd8;
	assign bgp = bg + 9'sd8;

	assign diff_ok = (dr >= -8'sd2) && (dr <= 8'sd1) && (dg >= -8'sd2) && (dg <= 8'sd1)
		&& (db >= -8'sd2) && (db <= 8'sd1);
	assign luma_ok = (dg >= -8'sd32) && (dg <= 8'sd31) && (rg >= -9'sd8) && (rg <= 9'sd7)
		&& (bg >= -9'sd8) && (bg <= 9'sd7);

	always_comb begin
		main_b   = '0;
		main_n   = 3'd0;
		run_en   = 1'b0;
		run_byte = qpe_pkg::TAG_RUN;
		run_next = run_q;
		tbl_wr   = 1'b0;
		if (same) begin
			if ((run_inc == qpe_pkg::RUN_MAX) || eoi_s1) begin
				run_en   = 1'b1;
				run_byte = qpe_pkg::TAG_RUN | {2'b00, run_q};
				run_next = 6'd0;
			end else begin
				run_next = run_inc;
			end
		end else begin
			run_en   = (run_q != 6'd0);
			run_byte = qpe_pkg::TAG_RUN | {2'b00, run_q - 6'd1};
			run_next = 6'd0;
			if (entry_pix == pix_s1) begin
				main_b[0] = qpe_pkg::TAG_INDEX | {2'b00, hash_s1};
				main_n    = 3'd1;
			end else begin
				tbl_wr = 1'b1;
				if (pix_s1.a == prev_q.a) begin
					if (diff_ok) begin
						main_b[0] = qpe_pkg::TAG_DIFF
							| {2'b00, drp[1:0], dgp[1:0], dbp[1:0]};
						main_n    = 3'd1;
					end else if (luma_ok) begin
						main_b[0] = qpe_pkg::TAG_LUMA | {2'b00, dgl[5:0]};
						main_b[1] = {rgp[3:0], bgp[3:0]};
						main_n    = 3'd2;
					end else begin
						main_b[0] = qpe_pkg::TAG_RGB;
						main_b[1] = pix_s1.r;
						main_b[2] = pix_s1.g;
						main_b[3] = pix_s1.b;
						main_n    = 3'd4;
					end
				end else begin
					main_b[0] = qpe_pkg::TAG_RGBA;
					main_b[1] = pix_s1.r;
					main_b[2] = pix_s1.g;
					main_b[3] = pix_s1.b;
					main_b[4] = pix_s1.a;
					main_n    = 3'd5;
				end
			end
		end
	end

	assign push_entry.bytes = run_en ? {main_b, run_byte} : {8'h00, main_b};
	assign push_entry.nb    = run_en ? main_n + 3'd1 : main_n;
	assign push_entry.eoi   = eoi_s1;

	assign push_req = valid_s1 && ((push_entry.nb != 3'd0) || eoi_s1);
	assign go       = !push_req || !q_stat.full;
	assign fire     = valid_s1 && go;
	assign push     = push_req && !q_stat.full;
	assign in_stall = valid_s1 && !go;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= in_pix;
			hash_s1    <= in_hash;
			eoi_s1     <= end_of_image;
			fwd_s1     <= fire && tbl_wr && !eoi_s1 && (hash_s1 == in_hash);
			fwd_pix_s1 <= pix_s1;
			idx_ok_s1  <= vbits_q[in_hash] && !(fire && eoi_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= qpe_pkg::PIXEL_RESET;
			run_q   <= 6'd0;
			vbits_q <= '0;
		end else if (fire) begin
			if (eoi_s1) begin
				prev_q  <= qpe_pkg::PIXEL_RESET;
				run_q   <= 6'd0;
				vbits_q <= '0;
			end else begin
				run_q <= run_next;
				if (!same) begin
					prev_q <= pix_s1;
				end
				if (tbl_wr) begin
					vbits_q[hash_s1] <= 1'b1;
				end
			end
		end
	end

	qpe_ram #(
		.WIDTH(qpe_pkg::PIXEL_W),
		.DEPTH(qpe_pkg::INDEX_DEPTH)
	) u_index (
		.clk  (clk),
		.we   (fire && tbl_wr && !eoi_s1),
		.waddr(hash_s1),
		.wdata(pix_s1),
		.re   (accept),
		.raddr(in_hash),
		.rdata(ram_rdata)
	);

endmodule

// ===== sv/qpe_queue.sv =====
// ----------------------------------------------------------------------------
// qpe_queue
// short fifo of chunk lists between the front and back parts
// ----------------------------------------------------------------------------
module qpe_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  qpe_pkg::qpe_entry_t push_entry,
	input  logic                pop,
	output qpe_pkg::qpe_entry_t head,
	output qpe_pkg::qpe_qstat_t q_stat
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	qpe_pkg::qpe_entry_t mem_q [DEPTH];
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [CW-1:0]       cnt_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == CW'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/qpe_back.sv =====
// ----------------------------------------------------------------------------
// qpe_back
// walks one chunk list a byte per cycle into the output register while the output is not stalled
// ----------------------------------------------------------------------------
module qpe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  qpe_pkg::qpe_entry_t head,
	input  qpe_pkg::qpe_qstat_t q_stat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic                last_of_item,
	output logic                stream_end
);

	logic [3:0] cnt_q;
	logic [3:0] total;
	logic       is_last;
	logic       load;
	logic [7:0] cur_byte;

	assign total   = {1'b0, head.nb} + (head.eoi ? qpe_pkg::MARKER_LEN : 4'd0);
	assign is_last = (cnt_q == total - 4'd1);
	assign load    = !q_stat.empty && (!out_valid || !out_stall);
	assign pop     = load && is_last;

	always_comb begin
		if (cnt_q < {1'b0, head.nb}) begin
			cur_byte = head.bytes[cnt_q[2:0]];
		end else if (is_last) begin
			cur_byte = qpe_pkg::MARKER_LAST;
		end else begin
			cur_byte = qpe_pkg::MARKER_PAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= 4'd0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				cnt_q     <= is_last ? 4'd0 : cnt_q + 4'd1;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte     <= cur_byte;
			last_of_item <= is_last;
			stream_end   <= is_last && head.eoi;
		end
	end

endmodule

// ===== sv/qoi_pixel_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// qoi_pixel_encoder_unit
// streaming qoi chunk encoder, one rgba pixel in, chunk bytes out
// ----------------------------------------------------------------------------
// usage
//   input channel: one pixel per transfer (in_valid / in_stall), end_of_image
//   marks the final pixel of an image
//   output channel: one chunk byte per transfer (out_valid / out_stall);
//   last_of_item flags the final byte caused by a pixel, stream_end flags
//   the final end-marker byte; a pixel that only extends a run gives no bytes
//   path: the first byte of a pixel passes the pixel stage, the queue and the output register
//   throughput: one pixel per cycle while pixels give at most one byte each and
//   the output is not stalled; the output side moves one byte per cycle, so a pixel
//   giving k bytes holds the byte serialiser for k byte transfers (rgba: 5, end of image: up to 14)
//   the pixel stage is registered, the index lookup a registered ram read
//   reset: asynchronous; previous pixel becomes opaque black, run count and
//   all index valid bits clear, so no clearing pass is needed
//   stall: a stalled output holds its byte; the queue fills and then the
//   pixel stage stalls the input; once the final pixel of an image leaves the
//   pixel stage, its state returns to reset values; the next pixel starts a fresh image
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qoi_pixel_encoder_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] pixel_red,
	input  logic [7:0] pixel_green,
	input  logic [7:0] pixel_blue,
	input  logic [7:0] pixel_alpha,
	input  logic       end_of_image,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_item,
	output logic       stream_end
);

	// front to queue
	logic                push;
	qpe_pkg::qpe_entry_t push_entry;
	// queue to back
	qpe_pkg::qpe_entry_t head;
	qpe_pkg::qpe_qstat_t q_stat;
	logic                pop;

	// classification, run/index/previous-pixel state
	qpe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_red   (pixel_red),
		.pixel_green (pixel_green),
		.pixel_blue  (pixel_blue),
		.pixel_alpha (pixel_alpha),
		.end_of_image(end_of_image),
		.push        (push),
		.push_entry  (push_entry),
		.q_stat      (q_stat)
	);

	// decouples pixel rate from byte rate
	qpe_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	// byte serialiser with output register
	qpe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_item(last_of_item),
		.stream_end  (stream_end)
	);

	// end marker always closes a pixel's byte list and ends in 0x01
	`ASSERT_IMPL(a_end_is_last, clk, arst_n, out_valid && stream_end, last_of_item)
	`ASSERT_IMPL(a_end_byte, clk, arst_n, out_valid && stream_end, out_byte == qpe_pkg::MARKER_LAST)
	// the input only backs up when the queue is full
	`ASSERT_IMPL(a_stall_full, clk, arst_n, in_stall, q_stat.full)
	// the end marker is eight bytes, so two stream ends never follow each other
	`ASSERT_NEXT(a_end_once, clk, arst_n, out_valid && !out_stall && stream_end, !(out_valid && stream_end))

endmodule
